FILE: src/pl_pkg.sv
// ----------------------------------------------------------------------------
// pl_pkg: shared types and codes for the positional list engine
// Request and response beat layouts, request and status codes, and the
// control word broadcast along the row of list cells.
// ----------------------------------------------------------------------------
package pl_pkg;

   localparam int CAPACITY    = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int POS_WIDTH   = 5;
   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int IDX_WIDTH   = $clog2(CAPACITY);

   localparam logic [COUNT_WIDTH-1:0] CAPACITY_COUNT = COUNT_WIDTH'(CAPACITY);

   // request codes
   localparam logic [1:0] REQ_READ   = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [POS_WIDTH-1:0] position;
      logic signed [31:0]   item_value;
   } pl_req_type;

   typedef struct packed {
      logic signed [31:0]     read_value;
      logic [1:0]             status;
      logic [COUNT_WIDTH-1:0] entry_count;
   } pl_rsp_type;

   typedef struct packed {
      logic                  shift_up;
      logic                  shift_down;
      logic [POS_WIDTH-1:0]  position;
      logic [DATA_WIDTH-1:0] value;
   } pl_cell_ctrl_type;

endpackage

FILE: src/pl_cell.sv
// ----------------------------------------------------------------------------
// pl_cell: one list slot
// Holds one entry; on an insert it takes its left neighbor or the new value,
// on a remove it takes its right neighbor, depending on its own index.
// ----------------------------------------------------------------------------
module pl_cell
   import pl_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  pl_cell_ctrl_type      ctrl,
   input  logic [DATA_WIDTH-1:0] left_entry,
   input  logic [DATA_WIDTH-1:0] right_entry,
   output logic [DATA_WIDTH-1:0] entry
);

   localparam logic [POS_WIDTH-1:0] MY_POS = POS_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_up) begin
         if (MY_POS > ctrl.position) begin
            entry_in = left_entry;
         end else if (MY_POS == ctrl.position) begin
            entry_in = ctrl.value;
         end
      end else if (ctrl.shift_down) begin
         if (MY_POS >= ctrl.position) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: src/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list with insert/remove by position
// A row of list cells, one entry per cell, shifts on insert or remove; a
// shared count tracks the list length.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on req_data and are taken at a rising edge where start
//   is high and busy is low. busy stays low: every request finishes at the
//   edge that takes it, since all cells shift together in that cycle.
//   Each request gives one response beat on rsp_data, shown for exactly one
//   cycle with rsp_valid high, in the cycle right after the request edge.
//   Throughput is one request per cycle, since the cell row and the count
//   register both update at the edge that takes the request.
//   A read returns the entry at the position, or status RANGE and zero when
//   the position is at or past the count. An insert past the count is RANGE,
//   an insert into a full list is FULL; both leave the list as it was.
//   Request code 3 does nothing and answers OK.
//   Reset clears the count and the response strobe; cell contents are not
//   cleared, since only positions below the count are ever read.
//   The receiver cannot stall: a response beat not taken is gone.
// ----------------------------------------------------------------------------
module positional_list_engine
   import pl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  pl_req_type req_data,
   output logic       rsp_valid,
   output pl_rsp_type rsp_data
);

   logic                   accept;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   pl_rsp_type             rsp_ff;
   pl_rsp_type             rsp_in;
   logic                   rsp_valid_ff;
   pl_cell_ctrl_type       cell_ctrl;
   logic [COUNT_WIDTH-1:0] req_pos;

   // cell outputs, one per list position
   logic [DATA_WIDTH-1:0]  cell_q [CAPACITY];

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign req_pos = COUNT_WIDTH'(req_data.position);

   // Decode the request against the current count and build the broadcast
   // control for the cell row.
   always_comb begin
      rsp_in               = '0;
      rsp_in.status        = ST_OK;
      count_in             = count_ff;
      cell_ctrl.shift_up   = 1'b0;
      cell_ctrl.shift_down = 1'b0;
      cell_ctrl.position   = req_data.position;
      cell_ctrl.value      = req_data.item_value;
      case (req_data.req_type)
         REQ_READ: begin
            if (req_pos < count_ff) begin
               rsp_in.read_value = signed'(cell_q[req_data.position[IDX_WIDTH-1:0]]);
            end else begin
               rsp_in.status = ST_RANGE;
            end
         end
         REQ_INSERT: begin
            // range check wins over the full check
            if (req_pos > count_ff) begin
               rsp_in.status = ST_RANGE;
            end else if (count_ff == CAPACITY_COUNT) begin
               rsp_in.status = ST_FULL;
            end else begin
               cell_ctrl.shift_up = accept;
               count_in           = count_ff + COUNT_WIDTH'(1);
            end
         end
         REQ_REMOVE: begin
            if (req_pos < count_ff) begin
               cell_ctrl.shift_down = accept;
               count_in             = count_ff - COUNT_WIDTH'(1);
            end else begin
               rsp_in.status = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
      rsp_in.entry_count = count_in;
   end

   // Row of cells: each one sees its two neighbors; the ends see zero.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_entry;
      logic [DATA_WIDTH-1:0] right_entry;
      if (i == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_rest
         assign left_entry = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = cell_q[i+1];
      end
      pl_cell #(
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
      // hold the response payload for its one-cycle beat
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAPACITY_COUNT)
      else $error("list count above capacity");

   a_rsp_follows_req : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("request without response beat");

   a_rsp_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count == count_ff)
      else $error("response count differs from list count");

   a_full_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> count_ff == CAPACITY_COUNT)
      else $error("full status on a list that is not full");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      cell_ctrl.shift_up |=> count_ff == $past(count_ff) + COUNT_WIDTH'(1))
      else $error("insert did not grow the list");

endmodule
